// ----- rtl/mshr_load_coalescer_stall_assert.svh -----
// Assertion macros shared by the checker of the load coalescer
`ifndef MSHR_LOAD_COALESCER_STALL_ASSERT_SVH
`define MSHR_LOAD_COALESCER_STALL_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define MLC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlc assertion failed");

// Next-cycle implication, quiet while reset is high
`define MLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlc assertion failed");

`endif

// ----- rtl/mlc_pkg.sv -----
// Shared types and constants of the load coalescer
package mlc_pkg;

  localparam int IO_ADDR_W  = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int OFF_W      = 4;
  localparam int MAXL_W     = 5;
  localparam int LIF_W      = 5;
  localparam int KIND_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES   = 1'd1;

  localparam logic [OFF_W-1:0]  LINE_OFFSET_RESET = 4'd6;
  localparam logic [MAXL_W-1:0] MAX_LINES_RESET   = 5'd16;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_RESP = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALU   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
    logic cfg_we;
  } dp_cmd_t;

endpackage

// ----- rtl/mlc_ctrl.sv -----
// Controller: transaction handshake and evaluation sequencing
module mlc_ctrl
  import mlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;

  // a new transaction may enter in the cycle the held result leaves
  assign in_stall  = !((state == S_IDLE) || ((state == S_OUT) && !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;

  assign dp_cmd.load_in = accept;
  assign dp_cmd.exec    = (state == S_EXEC);
  assign dp_cmd.cfg_we  = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= accept ? S_EXEC : S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mlc_dp.sv -----
// Datapath: miss table, pending slot, config registers and result register
module mlc_dp
  import mlc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               dp_cmd,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd,
  input  logic [KIND_W-1:0]     insn_kind,
  input  logic                  resp_is_load,
  input  logic [IO_ADDR_W-1:0]  addr,
  output logic                  insn_taken,
  output logic                  req_valid,
  output logic                  req_is_load,
  output logic [IO_ADDR_W-1:0]  req_addr,
  output logic                  stalled_now,
  output logic [LIF_W-1:0]      lines_in_flight,
  output logic                  resp_error
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > MAXL_W) ? CW : MAXL_W;

  // configuration
  logic [OFF_W-1:0]  line_offset;
  logic [MAXL_W-1:0] max_lines;

  // captured transaction
  logic                 cmd_q;
  logic [KIND_W-1:0]    kind_q;
  logic                 resp_load_q;
  logic [ADDR_BITS-1:0] addr_q;

  // tracking state
  logic [ADDR_BITS-1:0]   line_table [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [CW-1:0]          line_count;
  logic                   stall_flag;
  logic                   pend_valid;
  logic                   pend_is_load;
  logic [ADDR_BITS-1:0]   pend_addr;

  // evaluation
  logic [ADDR_BITS-1:0]   line_mask;
  logic [ADDR_BITS-1:0]   key;
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] free_oh;
  logic [TABLE_DEPTH-1:0] ins_oh;
  logic [CW-1:0]          freed;
  logic [CMPW-1:0]        limit;
  logic                   at_limit;
  logic                   present;

  logic [TABLE_DEPTH-1:0] entry_valid_next;
  logic [CW-1:0]          line_count_next;
  logic                   stall_flag_next;
  logic                   pend_valid_next;
  logic                   pend_is_load_next;
  logic [ADDR_BITS-1:0]   pend_addr_next;
  logic                   taken;
  logic                   sent;
  logic                   sent_load;
  logic [ADDR_BITS-1:0]   sent_addr;
  logic                   err;
  logic                   have;
  logic                   have_load;
  logic [ADDR_BITS-1:0]   have_addr;

  assign line_mask = {ADDR_BITS{1'b1}} << line_offset;
  assign key = ((cmd_q == CMD_TICK) && pend_valid) ? pend_addr : addr_q;

  // masked compare against every live entry in parallel
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = entry_valid[i] && (((line_table[i] ^ key) & line_mask) == '0);
    end
  end

  always_comb begin
    freed = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      freed = freed + CW'(match[i]);
    end
  end

  assign present = |match;
  // lowest clear valid bit
  assign free_oh = ~entry_valid & (entry_valid + TABLE_DEPTH'(1));

  always_comb begin
    if (max_lines == '0) begin
      limit = CMPW'(1);
    end else if (CMPW'(max_lines) > CMPW'(TABLE_DEPTH)) begin
      limit = CMPW'(TABLE_DEPTH);
    end else begin
      limit = CMPW'(max_lines);
    end
  end
  assign at_limit = (CMPW'(line_count) >= limit);

  always_comb begin
    entry_valid_next  = entry_valid;
    line_count_next   = line_count;
    stall_flag_next   = stall_flag;
    pend_valid_next   = pend_valid;
    pend_is_load_next = pend_is_load;
    pend_addr_next    = pend_addr;
    ins_oh            = '0;
    taken             = 1'b0;
    sent              = 1'b0;
    sent_load         = 1'b0;
    sent_addr         = '0;
    err               = 1'b0;
    have              = 1'b0;
    have_load         = 1'b0;
    have_addr         = '0;

    if (cmd_q == CMD_RESP) begin
      if (resp_load_q) begin
        if (freed == '0) begin
          err = 1'b1;
        end else begin
          entry_valid_next = entry_valid & ~match;
          line_count_next  = (freed > line_count) ? '0 : line_count - freed;
          stall_flag_next  = 1'b0;
        end
      end
    end else if (!stall_flag) begin
      if (pend_valid) begin
        have      = 1'b1;
        have_load = pend_is_load;
        have_addr = pend_addr;
      end else if (kind_q != KIND_NONE) begin
        taken = 1'b1;
        if ((kind_q == KIND_LOAD) || (kind_q == KIND_STORE)) begin
          if (at_limit) begin
            pend_valid_next   = 1'b1;
            pend_is_load_next = (kind_q == KIND_LOAD);
            pend_addr_next    = addr_q;
            stall_flag_next   = 1'b1;
          end else begin
            have      = 1'b1;
            have_load = (kind_q == KIND_LOAD);
            have_addr = addr_q;
          end
        end
      end

      if (have) begin
        pend_valid_next = 1'b0;
        if (!have_load) begin
          sent      = 1'b1;
          sent_addr = have_addr;
        end else if (!present) begin
          if (!at_limit && (free_oh != '0)) begin
            ins_oh           = free_oh;
            entry_valid_next = entry_valid | free_oh;
            line_count_next  = line_count + CW'(1);
            sent             = 1'b1;
            sent_load        = 1'b1;
            sent_addr        = have_addr;
          end else begin
            // new line with no room: park it and stall again
            pend_valid_next   = 1'b1;
            pend_is_load_next = 1'b1;
            pend_addr_next    = have_addr;
            stall_flag_next   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset  <= LINE_OFFSET_RESET;
      max_lines    <= MAX_LINES_RESET;
      entry_valid  <= '0;
      line_count   <= '0;
      stall_flag   <= 1'b0;
      pend_valid   <= 1'b0;
      pend_is_load <= 1'b0;
      pend_addr    <= '0;
    end else begin
      if (dp_cmd.cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_OFFSET: line_offset <= cfg_data[OFF_W-1:0];
          CFG_MAX_LINES:   max_lines   <= cfg_data;
          default: ;
        endcase
      end
      if (dp_cmd.exec) begin
        entry_valid  <= entry_valid_next;
        line_count   <= line_count_next;
        stall_flag   <= stall_flag_next;
        pend_valid   <= pend_valid_next;
        pend_is_load <= pend_is_load_next;
        pend_addr    <= pend_addr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (ins_oh[i]) line_table[i] <= have_addr;
      end
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_q       <= cmd;
      kind_q      <= insn_kind;
      resp_load_q <= resp_is_load;
      addr_q      <= ADDR_BITS'(addr);
    end
    if (dp_cmd.exec) begin
      insn_taken      <= taken;
      req_valid       <= sent;
      req_is_load     <= sent_load;
      req_addr        <= IO_ADDR_W'(sent_addr);
      stalled_now     <= stall_flag_next;
      lines_in_flight <= LIF_W'(line_count_next);
      resp_error      <= err;
    end
  end

endmodule

// ----- rtl/mshr_load_coalescer_stall.sv -----
// Top level of the load coalescer: controller plus datapath
// Issue-side miss tracker. Each transaction is a tick (possibly offering an
// instruction) or a cache response, and yields exactly one result. A
// transaction is first captured into input registers, then its address is
// compared against all TABLE_DEPTH line entries in parallel and the table is
// updated; the result then sits in an output register, and the next transaction
// is taken in the same cycle that result is taken, so no new transaction enters
// before the last result leaves. Config writes are taken every cycle (cfg_ready is
// always high); write them only while no transaction is in flight.
module mshr_load_coalescer_stall
  import mlc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [KIND_W-1:0]     insn_kind,
  input  logic                  resp_is_load,
  input  logic [IO_ADDR_W-1:0]  addr,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  insn_taken,
  output logic                  req_valid,
  output logic                  req_is_load,
  output logic [IO_ADDR_W-1:0]  req_addr,
  output logic                  stalled_now,
  output logic [LIF_W-1:0]      lines_in_flight,
  output logic                  resp_error
);

  dp_cmd_t dp_cmd;

  mlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .dp_cmd    (dp_cmd)
  );

  mlc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .insn_kind       (insn_kind),
    .resp_is_load    (resp_is_load),
    .addr            (addr),
    .insn_taken      (insn_taken),
    .req_valid       (req_valid),
    .req_is_load     (req_is_load),
    .req_addr        (req_addr),
    .stalled_now     (stalled_now),
    .lines_in_flight (lines_in_flight),
    .resp_error      (resp_error)
  );

endmodule

// ----- rtl/mlc_checker.sv -----
// Port-level checker for the load coalescer, bound to the top level
`include "mshr_load_coalescer_stall_assert.svh"

module mlc_checker
  import mlc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 insn_taken,
  input logic                 req_valid,
  input logic                 req_is_load,
  input logic [IO_ADDR_W-1:0] req_addr,
  input logic                 resp_error
);

  // a held result stays offered
  `MLC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // no request means cleared request fields
  `MLC_ASSERT_NOW(a_no_req_zero, clk, rst, out_valid && !req_valid,
                  (req_addr == '0) && !req_is_load)

  // an unmatched response never issues or consumes anything
  `MLC_ASSERT_NOW(a_err_quiet, clk, rst, out_valid && resp_error,
                  !insn_taken && !req_valid)

  // load kind only on a sent request
  `MLC_ASSERT_NOW(a_load_sent, clk, rst, out_valid && req_is_load, req_valid)

endmodule

bind mshr_load_coalescer_stall mlc_checker u_mlc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .insn_taken  (insn_taken),
  .req_valid   (req_valid),
  .req_is_load (req_is_load),
  .req_addr    (req_addr),
  .resp_error  (resp_error)
);

// ----- verif/mshr_load_coalescer_stall_tb.sv -----
// Self-checking testbench for the load coalescer: directed table, then random phases
module mshr_load_coalescer_stall_tb;
  import mlc_pkg::*;

  localparam int DEPTH           = 16;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int HOLD_CYCLES     = 300;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic                 cmd;
    logic [KIND_W-1:0]    kind;
    logic                 resp_load;
    logic [IO_ADDR_W-1:0] addr;
  } txn_t;

  typedef struct packed {
    logic                 taken;
    logic                 sent;
    logic                 sent_load;
    logic [IO_ADDR_W-1:0] sent_addr;
    logic                 stalled;
    logic [LIF_W-1:0]     lif;
    logic                 err;
  } res_t;

  typedef struct {
    bit                    is_cfg;
    bit                    fixed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    txn_t                  t;
    res_t                  r;
  } row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] off_data;
    logic [CFG_DATA_W-1:0] maxl_data;
    idle_mode_t            mode;
    bit                    pressure;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_TICK;
  logic [KIND_W-1:0]     insn_kind = KIND_NONE;
  logic                  resp_is_load = 1'b0;
  logic [IO_ADDR_W-1:0]  addr = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  insn_taken;
  logic                  req_valid;
  logic                  req_is_load;
  logic [IO_ADDR_W-1:0]  req_addr;
  logic                  stalled_now;
  logic [LIF_W-1:0]      lines_in_flight;
  logic                  resp_error;

  mshr_load_coalescer_stall i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .insn_kind       (insn_kind),
    .resp_is_load    (resp_is_load),
    .addr            (addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .insn_taken      (insn_taken),
    .req_valid       (req_valid),
    .req_is_load     (req_is_load),
    .req_addr        (req_addr),
    .stalled_now     (stalled_now),
    .lines_in_flight (lines_in_flight),
    .resp_error      (resp_error)
  );

  // miss table shadow
  logic [IO_ADDR_W-1:0] miss_line [DEPTH];
  bit                   miss_vld  [DEPTH];
  int unsigned          miss_count;
  bit                   issue_stall;
  bit                   pend_vld;
  bit                   pend_load;
  logic [IO_ADDR_W-1:0] pend_addr;
  logic [OFF_W-1:0]     cur_off;
  logic [MAXL_W-1:0]    cur_maxl;

  res_t                 expected_res_q [$];
  row_t                 dir_rows [$];
  logic [IO_ADDR_W-1:0] line_pool [8];
  int                   mismatches = 0;
  int                   send_pct = 0;
  int                   recv_pct = 0;
  bit                   hold_arm = 1'b0;
  int                   hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [IO_ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[IO_ADDR_W-1:0];
  endfunction

  function automatic bit same_line(logic [IO_ADDR_W-1:0] x, logic [IO_ADDR_W-1:0] y);
    return (x >> cur_off) == (y >> cur_off);
  endfunction

  // random address inside the line of a
  function automatic logic [IO_ADDR_W-1:0] in_line(logic [IO_ADDR_W-1:0] a);
    logic [IO_ADDR_W-1:0] mask;
    mask = (48'h1 << cur_off) - 48'h1;
    return (a & ~mask) | (rand48() & mask);
  endfunction

  function automatic res_t mk_res(bit tk, bit sn, bit ld, logic [IO_ADDR_W-1:0] a,
                                  bit st, int lif, bit er);
    res_t r;
    r.taken     = tk;
    r.sent      = sn;
    r.sent_load = ld;
    r.sent_addr = a;
    r.stalled   = st;
    r.lif       = lif[LIF_W-1:0];
    r.err       = er;
    return r;
  endfunction

  function automatic txn_t mk_txn(logic c, logic [KIND_W-1:0] k, logic rl,
                                  logic [IO_ADDR_W-1:0] a);
    txn_t t;
    t.cmd       = c;
    t.kind      = k;
    t.resp_load = rl;
    t.addr      = a;
    return t;
  endfunction

  function automatic res_t predict_issue(txn_t t);
    res_t                 r;
    bit                   have;
    bit                   is_load;
    bit                   done;
    bit                   held;
    logic [IO_ADDR_W-1:0] ia;
    int                   freed;
    int                   slot;
    int                   lim;
    r       = '0;
    have    = 1'b0;
    is_load = 1'b0;
    ia      = '0;
    lim     = int'(cur_maxl);
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    if (t.cmd == CMD_RESP) begin
      // store acks fall through untouched
      if (t.resp_load) begin
        freed = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (miss_vld[i] && same_line(miss_line[i], t.addr)) begin
            miss_vld[i] = 1'b0;
            freed++;
          end
        end
        if (freed == 0) begin
          r.err = 1'b1;
        end else begin
          miss_count  = (freed > miss_count) ? 0 : miss_count - freed;
          issue_stall = 1'b0;
        end
      end
    end else if (!issue_stall) begin
      if (pend_vld) begin
        have    = 1'b1;
        is_load = pend_load;
        ia      = pend_addr;
      end else if (t.kind != KIND_NONE) begin
        r.taken = 1'b1;
        if (t.kind == KIND_LOAD || t.kind == KIND_STORE) begin
          if (miss_count >= lim) begin
            pend_vld    = 1'b1;
            pend_load   = (t.kind == KIND_LOAD);
            pend_addr   = t.addr;
            issue_stall = 1'b1;
          end else begin
            have    = 1'b1;
            is_load = (t.kind == KIND_LOAD);
            ia      = t.addr;
          end
        end
      end
      if (have) begin
        done = 1'b1;
        if (!is_load) begin
          r.sent      = 1'b1;
          r.sent_addr = ia;
        end else begin
          held = 1'b0;
          for (int i = 0; i < DEPTH; i++)
            if (miss_vld[i] && same_line(miss_line[i], ia)) held = 1'b1;
          if (!held) begin
            slot = -1;
            if (miss_count < lim)
              for (int i = 0; i < DEPTH; i++)
                if (!miss_vld[i] && slot < 0) slot = i;
            if (slot < 0) begin
              done = 1'b0;
            end else begin
              miss_line[slot] = ia;
              miss_vld[slot]  = 1'b1;
              miss_count++;
              r.sent      = 1'b1;
              r.sent_load = 1'b1;
              r.sent_addr = ia;
            end
          end
        end
        if (done) begin
          pend_vld = 1'b0;
        end else begin
          // new line still blocked by a lowered limit
          pend_vld    = 1'b1;
          pend_load   = 1'b1;
          pend_addr   = ia;
          issue_stall = 1'b1;
        end
      end
    end
    r.stalled = issue_stall;
    r.lif     = miss_count[LIF_W-1:0];
    return r;
  endfunction

  // loads and stores mostly to a few hot lines, and responses that mostly retire held lines
  function automatic txn_t gen_txn();
    txn_t t;
    int   held_idx [$];
    int   r;
    int   k;
    t.cmd       = CMD_TICK;
    t.kind      = KIND_W'($urandom());
    t.resp_load = 1'($urandom());
    t.addr      = rand48();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      t.cmd = CMD_RESP;
      for (int i = 0; i < DEPTH; i++)
        if (miss_vld[i]) held_idx = {held_idx, i};
      if (r < 24 && held_idx.size() > 0) begin
        t.resp_load = 1'b1;
        t.addr = in_line(miss_line[held_idx[$urandom_range(0, held_idx.size() - 1)]]);
      end else if (r < 27) begin
        t.resp_load = 1'b1;
        t.addr = in_line(line_pool[$urandom_range(0, 7)]);
      end else begin
        t.resp_load = 1'b0;
      end
    end else begin
      k = $urandom_range(0, 99);
      if (k < 45)      t.kind = KIND_LOAD;
      else if (k < 65) t.kind = KIND_STORE;
      else if (k < 80) t.kind = KIND_ALU;
      else             t.kind = KIND_NONE;
      if ($urandom_range(0, 99) < 85) t.addr = in_line(line_pool[$urandom_range(0, 7)]);
    end
    return t;
  endfunction

  task automatic add_txn(logic c, logic [KIND_W-1:0] k, logic rl, logic [IO_ADDR_W-1:0] a);
    row_t row;
    row = '{is_cfg: 1'b0, fixed: 1'b0, idx: '0, data: '0, t: mk_txn(c, k, rl, a), r: '0};
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_fixed(logic c, logic [KIND_W-1:0] k, logic rl, logic [IO_ADDR_W-1:0] a,
                           res_t r);
    row_t row;
    row = '{is_cfg: 1'b0, fixed: 1'b1, idx: '0, data: '0, t: mk_txn(c, k, rl, a), r: r};
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = '{is_cfg: 1'b1, fixed: 1'b0, idx: idx, data: data, t: '0, r: '0};
    dir_rows = {dir_rows, row};
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LINE_OFFSET) cur_off = data[OFF_W-1:0];
    else cur_maxl = data[MAXL_W-1:0];
  endtask

  // caller has already dropped in_valid
  task automatic wait_idle();
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic drive_txn(txn_t t, bit fixed, res_t fixed_res);
    res_t p;
    int   gap;
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= t.cmd;
    insn_kind    <= t.kind;
    resp_is_load <= t.resp_load;
    addr         <= t.addr;
    do @(posedge clk); while (in_stall);
    p = predict_issue(t);
    if (fixed) p = fixed_res;
    expected_res_q = {expected_res_q, p};
  endtask

  task automatic set_idle(idle_mode_t m);
    send_pct = (m == IDLE_SEND) ? 52 : (m == IDLE_BOTH) ? 25 : 0;
    recv_pct = (m == IDLE_RECV) ? 52 : (m == IDLE_BOTH) ? 25 : 0;
  endtask

  task automatic check_field(string name, logic [IO_ADDR_W-1:0] got,
                             logic [IO_ADDR_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // receiver: random stall, or a long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_pct > 0) && ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result with no transaction waiting");
      end else begin
        e = expected_res_q.pop_front();
        check_field("insn_taken", 48'(insn_taken), 48'(e.taken));
        check_field("req_valid", 48'(req_valid), 48'(e.sent));
        check_field("req_is_load", 48'(req_is_load), 48'(e.sent_load));
        check_field("req_addr", req_addr, e.sent_addr);
        check_field("stalled_now", 48'(stalled_now), 48'(e.stalled));
        check_field("lines_in_flight", 48'(lines_in_flight), 48'(e.lif));
        check_field("resp_error", 48'(resp_error), 48'(e.err));
      end
    end
  end

  initial begin
    phase_t phases [10];
    bit     in_cfg;
    logic [IO_ADDR_W-1:0] ones;
    ones = '1;
    phases[0] = '{5'd6,  5'd16, IDLE_NONE, 1'b0};
    phases[1] = '{5'd0,  5'd4,  IDLE_SEND, 1'b0};
    phases[2] = '{5'd12, 5'd16, IDLE_RECV, 1'b0};
    phases[3] = '{5'd15, 5'd1,  IDLE_BOTH, 1'b0};
    phases[4] = '{5'd19, 5'd31, IDLE_NONE, 1'b0};
    phases[5] = '{5'd6,  5'd8,  IDLE_SEND, 1'b0};
    phases[6] = '{5'd9,  5'd2,  IDLE_RECV, 1'b0};
    phases[7] = '{5'd13, 5'd0,  IDLE_BOTH, 1'b0};
    phases[8] = '{5'd6,  5'd16, IDLE_NONE, 1'b1};
    phases[9] = '{5'd4,  5'd12, IDLE_BOTH, 1'b0};

    // reset values, offset 6 and limit 16
    add_fixed(CMD_TICK, KIND_NONE, 1'b0, '0, mk_res(0, 0, 0, '0, 0, 0, 0));
    add_fixed(CMD_RESP, KIND_NONE, 1'b1, ones, mk_res(0, 0, 0, '0, 0, 0, 1));
    add_fixed(CMD_RESP, KIND_STORE, 1'b0, 48'h123, mk_res(0, 0, 0, '0, 0, 0, 0));
    add_fixed(CMD_TICK, KIND_ALU, 1'b1, ones, mk_res(1, 0, 0, '0, 0, 0, 0));
    add_fixed(CMD_TICK, KIND_LOAD, 1'b0, '0, mk_res(1, 1, 1, '0, 0, 1, 0));
    add_fixed(CMD_TICK, KIND_LOAD, 1'b0, 48'h3F, mk_res(1, 0, 0, '0, 0, 1, 0));
    add_fixed(CMD_TICK, KIND_STORE, 1'b0, ones, mk_res(1, 1, 0, ones, 0, 1, 0));
    // limit clamps up to one: memory op at the limit goes pending
    add_cfg(CFG_LINE_OFFSET, 5'h10);
    add_cfg(CFG_MAX_LINES, 5'd0);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h5);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h9);
    add_txn(CMD_RESP, KIND_NONE, 1'b1, 48'h0);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h9);
    add_txn(CMD_TICK, KIND_STORE, 1'b0, 48'h77);
    add_txn(CMD_RESP, KIND_NONE, 1'b1, 48'h5);
    add_txn(CMD_TICK, KIND_ALU, 1'b0, 48'h0);
    // offset past 12 and limit past the table depth
    add_cfg(CFG_LINE_OFFSET, 5'h1F);
    add_cfg(CFG_MAX_LINES, 5'd31);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h4000);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h7FFF);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h8000);
    add_cfg(CFG_LINE_OFFSET, 5'd0);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h8001);
    // wider lines: one response frees two entries
    add_cfg(CFG_LINE_OFFSET, 5'd1);
    add_cfg(CFG_MAX_LINES, 5'd3);
    add_txn(CMD_RESP, KIND_NONE, 1'b1, 48'h8000);
    add_cfg(CFG_LINE_OFFSET, 5'd12);
    add_cfg(CFG_MAX_LINES, 5'd2);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h1000);
    add_txn(CMD_TICK, KIND_LOAD, 1'b0, 48'h2000);
    add_txn(CMD_RESP, KIND_NONE, 1'b1, 48'h1FFF);
    // lowered limit blocks the pending new-line load again
    add_cfg(CFG_MAX_LINES, 5'd1);
    add_txn(CMD_TICK, KIND_NONE, 1'b0, 48'h0);
    add_txn(CMD_RESP, KIND_NONE, 1'b1, 48'h4ABC);
    add_txn(CMD_TICK, KIND_NONE, 1'b0, 48'h0);

    for (int i = 0; i < DEPTH; i++) begin
      miss_line[i] = '0;
      miss_vld[i]  = 1'b0;
    end
    miss_count  = 0;
    issue_stall = 1'b0;
    pend_vld    = 1'b0;
    pend_load   = 1'b0;
    pend_addr   = '0;
    cur_off     = LINE_OFFSET_RESET;
    cur_maxl    = MAX_LINES_RESET;
    for (int i = 0; i < 8; i++) line_pool[i] = rand48();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!in_cfg) begin
          in_valid <= 1'b0;
          wait_idle();
        end
        write_cfg(dir_rows[i].idx, dir_rows[i].data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        drive_txn(dir_rows[i].t, dir_rows[i].fixed, dir_rows[i].r);
      end
    end

    foreach (phases[p]) begin
      in_valid <= 1'b0;
      wait_idle();
      write_cfg(CFG_LINE_OFFSET, phases[p].off_data);
      write_cfg(CFG_MAX_LINES, phases[p].maxl_data);
      cfg_valid <= 1'b0;
      set_idle(phases[p].mode);
      for (int i = 0; i < 8; i++) line_pool[i] = rand48();
      if (phases[p].pressure) hold_arm = 1'b1;
      repeat (ITEMS_PER_PHASE) drive_txn(gen_txn(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
